### rtl/matrix_inverse_4x4_unit_defines.svh
// assertion macros for the 4x4 matrix inverse unit
`ifndef MATRIX_INVERSE_4X4_UNIT_DEFINES_SVH
`define MATRIX_INVERSE_4X4_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MI4_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MI4_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mi4_pkg.sv
// package: widths, command and status types, minor address helper
`default_nettype none
package mi4_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int LIMBS     = 4;
  localparam int X_W       = LIMBS * WORD_BITS;
  localparam int ACC_W     = X_W + 4;
  localparam int COF_W     = 3 * WORD_BITS + 2;
  localparam int DIV_W     = ACC_W + WORD_BITS;
  localparam int RND_SHIFT = 2 * FRAC_BITS + 1;
  localparam int BIT_W     = 6;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR_ACC,
    OP_LOAD_X_MEM,
    OP_MUL_X,
    OP_MAC,
    OP_STORE_COF,
    OP_LOAD_X_COF,
    OP_STORE_DET,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT,
    OP_EMIT_SING
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_TERM,
    S_COF,
    S_DCLR,
    S_DLOAD,
    S_DMAC,
    S_DSTORE,
    S_CHECK,
    S_SING,
    S_DINIT,
    S_DSTEP,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] raddr;
    logic [1:0] limb;
    logic       top;
    logic       sub;
    logic [3:0] idx;
    logic       first;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
  } stat_t;

  // index j of the three kept rows/cols, skipping the removed one
  function automatic logic [1:0] skip_idx(input logic [1:0] removed, input logic [1:0] j);
    logic [1:0] r;
    begin
      r = (j >= removed) ? j + 2'd1 : j;
      return r;
    end
  endfunction

  // column permutation for the six 3x3 terms, entry j in bits [2j+1:2j]
  function automatic logic [1:0] perm3(input logic [2:0] p, input logic [1:0] j);
    logic [5:0] row;
    begin
      case (p)
        3'd0: row = 6'b10_01_00;
        3'd1: row = 6'b00_10_01;
        3'd2: row = 6'b01_00_10;
        3'd3: row = 6'b01_10_00;
        3'd4: row = 6'b10_00_01;
        3'd5: row = 6'b00_01_10;
        default: row = 6'b10_01_00;
      endcase
      return row[{j, 1'b0} +: 2];
    end
  endfunction

  // store address of factor j of term p of the minor without row sr, col sc
  function automatic logic [3:0] minor_addr(input logic [1:0] sr, input logic [1:0] sc,
                                            input logic [2:0] p, input logic [1:0] j);
    logic [3:0] a;
    begin
      a = {skip_idx(sr, j), skip_idx(sc, perm3(p, j))};
      return a;
    end
  endfunction

endpackage
`default_nettype wire

### rtl/matrix_inverse_4x4_unit.sv
// top level: 4x4 matrix inverse by adjugate, signed Q16.16
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | start / busy       | in_row_index, in_col_index, in_element_value,
//           |                    | in_start_invert
//  result   | out_strobe         | out_row, out_col, out_value, out_singular,
//           |                    | out_saturated, out_last_result
//
// a load transfer is accepted while start is high and busy is low; the marked last element
// starts a run: 16 cofactors on one shared 33x33 multiply-accumulate, then the determinant,
// then each element through the restoring divider, or one singular result if the determinant is 0
// busy stays high for the whole run; results come one per divide, each strobed once
// synchronous active-low reset clears the controller and the strobe; the element
// store is not cleared and must be fully written before the first run
// the result side cannot stall, so each result is dropped onto the ports for one cycle
`default_nettype none
module matrix_inverse_4x4_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           in_row_index,
  input  wire logic [1:0]                           in_col_index,
  input  wire logic signed [mi4_pkg::WORD_BITS-1:0] in_element_value,
  input  wire logic                                 in_start_invert,
  output logic                                      out_strobe,
  output logic [1:0]                                out_row,
  output logic [1:0]                                out_col,
  output logic signed [mi4_pkg::WORD_BITS-1:0]      out_value,
  output logic                                      out_singular,
  output logic                                      out_saturated,
  output logic                                      out_last_result
);
  import mi4_pkg::*;

  `include "matrix_inverse_4x4_unit_defines.svh"

  cmd_t  cmd;
  stat_t stat;
  logic  in_xfer;
  logic  go;

  // input transfer writes the store; the marked one also kicks off a run
  assign in_xfer = start && !busy;
  assign go      = in_xfer && in_start_invert;

  mi4_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mi4_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .wr_en           (in_xfer),
    .wr_addr         ({in_row_index, in_col_index}),
    .wr_data         (in_element_value),
    .stat            (stat),
    .out_strobe      (out_strobe),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value       (out_value),
    .out_singular    (out_singular),
    .out_saturated   (out_saturated),
    .out_last_result (out_last_result)
  );

  // a run start always raises busy
  `MI4_ASSERT_NXT(a_go_busy, go, busy, "run start did not raise busy")
  // singular result is the only one of its run
  `MI4_ASSERT_IMP(a_sing_last, out_strobe && out_singular, out_last_result && out_value == 0 && !out_saturated, "bad singular result")
  // the final result leaves the unit idle
  `MI4_ASSERT_IMP(a_last_idle, out_strobe && out_last_result, !busy, "busy after final result")
  // nothing follows the final result
  `MI4_ASSERT_NXT(a_last_quiet, out_strobe && out_last_result, !out_strobe, "result after final")

endmodule
`default_nettype wire

### rtl/mi4_ctrl.sv
// controller: sequences cofactors, determinant, division and result transfers
`default_nettype none
module mi4_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  wire mi4_pkg::stat_t stat,
  output mi4_pkg::cmd_t      cmd,
  output logic               busy
);
  import mi4_pkg::*;

  state_t           state_r, state_nxt;
  logic [3:0]       ci_r, ci_nxt;
  logic [2:0]       p_r, p_nxt;
  logic [2:0]       ph_r, ph_nxt;
  logic [1:0]       k_r, k_nxt;
  logic [1:0]       i_r, i_nxt;
  logic [3:0]       e_r, e_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic [1:0]       sr, sc;
  logic             tsign;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ci_r    <= '0;
      p_r     <= '0;
      ph_r    <= '0;
      k_r     <= '0;
      i_r     <= '0;
      e_r     <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ci_r    <= ci_nxt;
      p_r     <= p_nxt;
      ph_r    <= ph_nxt;
      k_r     <= k_nxt;
      i_r     <= i_nxt;
      e_r     <= e_nxt;
      bit_r   <= bit_nxt;
    end
  end

  assign sr    = ci_r[3:2];
  assign sc    = ci_r[1:0];
  assign tsign = (p_r >= 3'd3) ^ sr[0] ^ sc[0];
  assign busy  = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ci_nxt    = ci_r;
    p_nxt     = p_r;
    ph_nxt    = ph_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    e_nxt     = e_r;
    bit_nxt   = bit_r;
    cmd       = '0;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          ci_nxt    = '0;
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        cmd.op    = OP_CLR_ACC;
        p_nxt     = '0;
        ph_nxt    = '0;
        state_nxt = S_TERM;
      end
      S_TERM: begin
        cmd.sub = tsign;
        case (ph_r)
          3'd0: cmd.raddr = minor_addr(sr, sc, p_r, 2'd0);
          3'd1: begin
            cmd.op    = OP_LOAD_X_MEM;
            cmd.raddr = minor_addr(sr, sc, p_r, 2'd1);
          end
          3'd2: begin
            cmd.op    = OP_MUL_X;
            cmd.raddr = minor_addr(sr, sc, p_r, 2'd2);
          end
          3'd3: begin
            cmd.op    = OP_MAC;
            cmd.limb  = 2'd0;
            cmd.raddr = minor_addr(sr, sc, p_r, 2'd2);
          end
          default: begin
            cmd.op    = OP_MAC;
            cmd.limb  = 2'd1;
            cmd.top   = 1'b1;
            cmd.raddr = minor_addr(sr, sc, p_r, 2'd2);
          end
        endcase
        if (ph_r == 3'd4) begin
          ph_nxt = '0;
          if (p_r == 3'd5) begin
            state_nxt = S_COF;
          end else begin
            p_nxt = p_r + 3'd1;
          end
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end
      S_COF: begin
        cmd.op  = OP_STORE_COF;
        cmd.idx = ci_r;
        if (ci_r == 4'd15) begin
          i_nxt     = '0;
          state_nxt = S_DCLR;
        end else begin
          ci_nxt    = ci_r + 4'd1;
          state_nxt = S_CLR;
        end
      end
      S_DCLR: begin
        cmd.op    = OP_CLR_ACC;
        state_nxt = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.op    = OP_LOAD_X_COF;
        cmd.idx   = {i_r, 2'd0};
        cmd.raddr = {i_r, 2'd0};
        k_nxt     = '0;
        state_nxt = S_DMAC;
      end
      S_DMAC: begin
        cmd.op    = OP_MAC;
        cmd.limb  = k_r;
        cmd.top   = (k_r == 2'd3);
        cmd.raddr = {i_r, 2'd0};
        k_nxt     = k_r + 2'd1;
        if (k_r == 2'd3) begin
          if (i_r == 2'd3) begin
            state_nxt = S_DSTORE;
          end else begin
            i_nxt     = i_r + 2'd1;
            state_nxt = S_DLOAD;
          end
        end
      end
      S_DSTORE: begin
        cmd.op    = OP_STORE_DET;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        e_nxt     = '0;
        state_nxt = stat.det_zero ? S_SING : S_DINIT;
      end
      S_SING: begin
        cmd.op    = OP_EMIT_SING;
        state_nxt = S_IDLE;
      end
      S_DINIT: begin
        cmd.op    = OP_DIV_INIT;
        cmd.idx   = {e_r[1:0], e_r[3:2]};
        bit_nxt   = '0;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op    = OP_DIV_STEP;
        cmd.first = (bit_r == '0);
        bit_nxt   = bit_r + BIT_W'(1);
        if (bit_r == BIT_W'(WORD_BITS)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.op   = OP_EMIT;
        cmd.idx  = e_r;
        cmd.last = (e_r == 4'd15);
        if (e_r == 4'd15) begin
          state_nxt = S_IDLE;
        end else begin
          e_nxt     = e_r + 4'd1;
          state_nxt = S_DINIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/mi4_dp.sv
// datapath: element store, multiply-accumulate, cofactor file, divider, result register
`default_nettype none
module mi4_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire mi4_pkg::cmd_t                        cmd,
  input  wire logic                                 wr_en,
  input  wire logic [3:0]                           wr_addr,
  input  wire logic signed [mi4_pkg::WORD_BITS-1:0] wr_data,
  output mi4_pkg::stat_t                            stat,
  output logic                                      out_strobe,
  output logic [1:0]                                out_row,
  output logic [1:0]                                out_col,
  output logic signed [mi4_pkg::WORD_BITS-1:0]      out_value,
  output logic                                      out_singular,
  output logic                                      out_saturated,
  output logic                                      out_last_result
);
  import mi4_pkg::*;

  logic [WORD_BITS-1:0]        mem_r [16];
  logic [WORD_BITS-1:0]        rd_r;
  logic signed [X_W-1:0]       x_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic signed [COF_W-1:0]     cof_r [16];
  logic [ACC_W-1:0]            det_mag_r;
  logic                        det_neg_r;
  logic                        det_zero_r;
  logic [DIV_W-1:0]            rem_r;
  logic [DIV_W-1:0]            dsr_r;
  logic [WORD_BITS-1:0]        q_r;
  logic                        ovf_r;
  logic                        neg_r;
  logic                        strobe_r;
  logic [1:0]                  row_r, col_r;
  logic [WORD_BITS-1:0]        val_r;
  logic                        sing_r, sat_r, last_r;

  logic signed [2*WORD_BITS-1:0]   prod64;
  logic [WORD_BITS-1:0]            limb;
  logic signed [WORD_BITS:0]       limb_s, rd_s;
  logic signed [2*WORD_BITS+1:0]   prod_mac;
  logic signed [ACC_W-1:0]         mac_term;
  logic signed [COF_W-1:0]         cof_sel;
  logic [COF_W-1:0]                cof_mag;
  logic [DIV_W-1:0]                num_init, dsr_init;
  logic                            ge;
  logic [WORD_BITS-1:0]            lim, qv;
  logic                            sat_c;

  // element store, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_r <= mem_r[cmd.raddr];
  end

  always_comb begin
    prod64   = $signed(x_r[WORD_BITS-1:0]) * $signed(rd_r);
    limb     = x_r[cmd.limb*WORD_BITS +: WORD_BITS];
    limb_s   = cmd.top ? $signed({limb[WORD_BITS-1], limb}) : $signed({1'b0, limb});
    rd_s     = $signed({rd_r[WORD_BITS-1], rd_r});
    prod_mac = limb_s * rd_s;
    mac_term = ACC_W'(prod_mac) <<< {cmd.limb, 5'd0};
    cof_sel  = cof_r[cmd.idx];
    cof_mag  = cof_sel[COF_W-1] ? COF_W'(-cof_sel) : COF_W'(cof_sel);
    num_init = (DIV_W'(cof_mag) << RND_SHIFT) + DIV_W'(det_mag_r);
    dsr_init = DIV_W'(det_mag_r) << (WORD_BITS + 1);
    ge       = (rem_r >= dsr_r);
    lim      = neg_r ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
    sat_c    = ovf_r || (q_r > lim);
    qv       = sat_c ? lim : q_r;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CLR_ACC:    acc_r <= '0;
      OP_LOAD_X_MEM: x_r <= X_W'($signed(rd_r));
      OP_MUL_X:      x_r <= X_W'(prod64);
      OP_MAC:        acc_r <= cmd.sub ? acc_r - mac_term : acc_r + mac_term;
      OP_STORE_COF:  cof_r[cmd.idx] <= acc_r[COF_W-1:0];
      OP_LOAD_X_COF: x_r <= X_W'(cof_sel);
      OP_STORE_DET: begin
        det_neg_r  <= acc_r[ACC_W-1];
        det_mag_r  <= acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
        det_zero_r <= (acc_r == '0);
      end
      OP_DIV_INIT: begin
        rem_r <= num_init;
        dsr_r <= dsr_init;
        neg_r <= cof_sel[COF_W-1] ^ det_neg_r;
        q_r   <= '0;
        ovf_r <= 1'b0;
      end
      OP_DIV_STEP: begin
        if (ge) begin
          rem_r <= rem_r - dsr_r;
        end
        dsr_r <= dsr_r >> 1;
        if (cmd.first) begin
          ovf_r <= ge;
        end else begin
          q_r <= {q_r[WORD_BITS-2:0], ge};
        end
      end
      default: ;
    endcase
  end

  // result register, strobe high for one cycle per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (cmd.op == OP_EMIT) || (cmd.op == OP_EMIT_SING);
    end
    if (cmd.op == OP_EMIT_SING) begin
      row_r  <= '0;
      col_r  <= '0;
      val_r  <= '0;
      sing_r <= 1'b1;
      sat_r  <= 1'b0;
      last_r <= 1'b1;
    end else begin
      row_r  <= cmd.idx[3:2];
      col_r  <= cmd.idx[1:0];
      val_r  <= neg_r ? WORD_BITS'(-qv) : qv;
      sing_r <= 1'b0;
      sat_r  <= sat_c;
      last_r <= cmd.last;
    end
  end

  assign stat.det_zero  = det_zero_r;
  assign out_strobe     = strobe_r;
  assign out_row        = row_r;
  assign out_col        = col_r;
  assign out_value      = $signed(val_r);
  assign out_singular   = sing_r;
  assign out_saturated  = sat_r;
  assign out_last_result = last_r;

endmodule
`default_nettype wire

### test/matrix_inverse_4x4_unit_tb.sv
// testbench for the 4x4 matrix inverse unit: exact wide-integer predictor and result checker
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_4x4_unit_tb;

  localparam int WB = mi4_pkg::WORD_BITS;
  localparam int FB = mi4_pkg::FRAC_BITS;
  localparam int XW = 240;  // wide enough for cofactor << (2*FB+1) plus carry
  localparam logic [WB-1:0] Q_ONE = 1 << FB;

  typedef struct {
    logic [1:0]    row;
    logic [1:0]    col;
    logic [WB-1:0] value;
    logic          singular;
    logic          saturated;
    logic          last;
  } inv_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_row_index = '0;
  logic [1:0] in_col_index = '0;
  logic signed [WB-1:0] in_element_value = '0;
  logic in_start_invert = 1'b0;
  logic out_strobe;
  logic [1:0] out_row;
  logic [1:0] out_col;
  logic signed [WB-1:0] out_value;
  logic out_singular;
  logic out_saturated;
  logic out_last_result;

  matrix_inverse_4x4_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_row_index(in_row_index), .in_col_index(in_col_index),
    .in_element_value(in_element_value), .in_start_invert(in_start_invert),
    .out_strobe(out_strobe), .out_row(out_row), .out_col(out_col),
    .out_value(out_value), .out_singular(out_singular),
    .out_saturated(out_saturated), .out_last_result(out_last_result)
  );

  inv_result_t pending_inverse[$];
  logic [WB-1:0] shadow_matrix[16];
  int error_count = 0;
  int burst_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // every item may start a full inversion run
  initial begin
    #25_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [WB-1:0] got,
                                 input logic [WB-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // 3x3 determinant of the minor without row sr and column sc, exact
  function automatic logic signed [XW-1:0] minor_det(input int sr, input int sc);
    logic signed [XW-1:0] m[3][3];
    int rs[3];
    int cs[3];
    int n;
    int k;
    n = 0;
    for (k = 0; k < 4; k++) if (k != sr) begin rs[n] = k; n++; end
    n = 0;
    for (k = 0; k < 4; k++) if (k != sc) begin cs[n] = k; n++; end
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        m[a][b] = XW'($signed(shadow_matrix[rs[a] * 4 + cs[b]]));
    return m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
         - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
         + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
  endfunction

  // inverse = transposed cofactors over determinant, rounded half away, saturated
  task automatic predict_inverse();
    logic signed [XW-1:0] cof[16];
    logic signed [XW-1:0] det;
    logic [XW-1:0] mag_cof;
    logic [XW-1:0] mag_det;
    logic [XW-1:0] quot;
    logic [XW-1:0] lim;
    logic neg;
    inv_result_t res;
    det = '0;
    for (int i = 0; i < 16; i++) begin
      cof[i] = minor_det(i / 4, i % 4);
      if (((i / 4) + (i % 4)) % 2 == 1) cof[i] = -cof[i];
    end
    for (int i = 0; i < 4; i++) det += XW'($signed(shadow_matrix[i * 4])) * cof[i * 4];
    if (det == 0) begin
      res = '{2'd0, 2'd0, '0, 1'b1, 1'b0, 1'b1};
      pending_inverse.push_back(res);
      return;
    end
    mag_det = (det < 0) ? -det : det;
    for (int k = 0; k < 16; k++) begin
      mag_cof = (cof[(k % 4) * 4 + k / 4] < 0) ? -cof[(k % 4) * 4 + k / 4]
                                                : cof[(k % 4) * 4 + k / 4];
      neg = (cof[(k % 4) * 4 + k / 4] < 0) != (det < 0);
      quot = ((mag_cof << (2 * FB + 1)) + mag_det) / (mag_det << 1);
      lim = neg ? (XW'(1) << (WB - 1)) : ((XW'(1) << (WB - 1)) - 1);
      res.saturated = quot > lim;
      if (res.saturated) quot = lim;
      res.value = neg ? WB'(-quot) : WB'(quot);
      res.row = 2'(k / 4);
      res.col = 2'(k % 4);
      res.singular = 1'b0;
      res.last = (k == 15);
      pending_inverse.push_back(res);
    end
  endtask

  // one load transfer; start stays high so back-to-back items need no dead cycle
  task automatic send_element(input logic [1:0] r, input logic [1:0] c,
                              input logic [WB-1:0] v, input logic inv);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start = 1'b1;
    in_row_index = r;
    in_col_index = c;
    in_element_value = v;
    in_start_invert = inv;
    do @(posedge clk); while (busy);
    shadow_matrix[{r, c}] = v;
    if (inv) predict_inverse();
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_inverse.size() != 0) @(negedge clk);
  endtask

  // result checker: the unit strobes each result for one cycle, no backpressure
  always @(posedge clk) begin
    inv_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_inverse.size() == 0) begin
        report_mismatch("unexpected result", out_value, '0);
      end else begin
        want = pending_inverse.pop_front();
        if (out_row !== want.row) report_mismatch("out_row", out_row, want.row);
        if (out_col !== want.col) report_mismatch("out_col", out_col, want.col);
        if (out_value !== want.value) report_mismatch("out_value", out_value, want.value);
        if (out_singular !== want.singular)
          report_mismatch("out_singular", out_singular, want.singular);
        if (out_saturated !== want.saturated)
          report_mismatch("out_saturated", out_saturated, want.saturated);
        if (out_last_result !== want.last)
          report_mismatch("out_last_result", out_last_result, want.last);
      end
    end
  end

  function automatic logic [WB-1:0] pick_value(input int mode);
    case (mode)
      0: return WB'($signed($urandom_range(0, 16 * Q_ONE)) - $signed(8 * Q_ONE));
      1: return $urandom;
      default: return WB'($signed($urandom_range(0, 16)) - 8) << FB;
    endcase
  endfunction

  // load a whole matrix in shuffled order, last transfer starts the inversion
  task automatic load_matrix(input int mode);
    logic [WB-1:0] m[16];
    int order[16];
    int j;
    int t;
    for (int i = 0; i < 16; i++) begin
      m[i] = pick_value(mode == 3 ? $urandom_range(0, 2) : mode);
      order[i] = i;
    end
    if (mode == 4) begin
      // singular when row t repeats row j; otherwise row t mixes entries of row j with zeros
      j = $urandom_range(0, 3);
      t = (j + $urandom_range(1, 3)) % 4;
      for (int c = 0; c < 4; c++) m[t * 4 + c] = $urandom_range(0, 1) ? m[j * 4 + c] : '0;
      if (m[t * 4] != 0 || $urandom_range(0, 1)) for (int c = 0; c < 4; c++)
        m[t * 4 + c] = m[j * 4 + c];
    end
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < 16; i++)
      send_element(2'(order[i] / 4), 2'(order[i] % 4), m[order[i]], i == 15);
  endtask

  // identity, then rewrites of the corners: extremes, saturation, singular
  task automatic test_directed();
    for (int i = 0; i < 16; i++)
      send_element(2'(i / 4), 2'(i % 4), (i % 5 == 0) ? Q_ONE : '0, i == 15);
    send_element(2'd0, 2'd0, {1'b0, {(WB - 1){1'b1}}}, 1'b1);
    send_element(2'd0, 2'd0, {1'b1, {(WB - 1){1'b0}}}, 1'b1);
    send_element(2'd0, 2'd0, WB'(1), 1'b1);
    send_element(2'd0, 2'd0, '0, 1'b1);
    send_element(2'd3, 2'd3, {WB{1'b1}}, 1'b0);
    send_element(2'd0, 2'd0, -Q_ONE, 1'b1);
  endtask

  // pause the sender until every expected result has come
  task automatic test_quiet_pause();
    load_matrix(0);
    drain_results();
  endtask

  // mostly full matrices with random content, some partial rewrites and noise
  task automatic test_random(input int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin load_matrix(0); sent += 16; end
        3, 4: begin load_matrix(1); sent += 16; end
        5: begin load_matrix(3); sent += 16; end
        6: begin load_matrix(4); sent += 16; end
        7: begin load_matrix(2); sent += 16; end
        default: begin
          n = $urandom_range(1, 5);
          for (int i = 0; i < n; i++)
            send_element(2'($urandom), 2'($urandom), pick_value($urandom_range(0, 2)),
                         i == n - 1);
          sent += n;
        end
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_quiet_pause();
    test_random(390);
    drain_results();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
